### sv/owm_pkg.sv
// Shared types and constants of the single-wire bus master.
package owm_pkg;

	// Register indexes of the configuration channel.
	localparam logic [2:0] REG_SHORT_PULSE = 3'd0;
	localparam logic [2:0] REG_LONG_PULSE  = 3'd1;
	localparam logic [2:0] REG_PRE_RESET   = 3'd2;
	localparam logic [2:0] REG_RESET_LOW   = 3'd3;
	localparam logic [2:0] REG_POST_RESET  = 3'd4;
	localparam logic [2:0] REG_READ_LOW    = 3'd5;

	localparam int CFG_W = 10;

	localparam logic [CFG_W-1:0] SHORT_PULSE_RST = 10'd10;
	localparam logic [CFG_W-1:0] LONG_PULSE_RST  = 10'd64;
	localparam logic [CFG_W-1:0] PRE_RESET_RST   = 10'd480;
	localparam logic [CFG_W-1:0] RESET_LOW_RST   = 10'd480;
	localparam logic [CFG_W-1:0] POST_RESET_RST  = 10'd350;
	localparam logic [CFG_W-1:0] READ_LOW_RST    = 10'd10;

	// Command codes.
	localparam logic [1:0] CMD_NONE  = 2'd0;
	localparam logic [1:0] CMD_RESET = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;
	localparam logic [1:0] CMD_READ  = 2'd3;

	// Status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BUS_LOW  = 2'd1;
	localparam logic [1:0] ST_NO_ECHO  = 2'd2;

	typedef struct packed {
		logic [CFG_W-1:0] short_pulse_us;
		logic [CFG_W-1:0] long_pulse_us;
		logic [CFG_W-1:0] pre_reset_us;
		logic [CFG_W-1:0] reset_low_us;
		logic [CFG_W-1:0] post_reset_us;
		logic [CFG_W-1:0] read_low_us;
	} owm_cfg_t;

	typedef struct packed {
		logic       tick;
		logic       bus_level;
		logic [7:0] write_data;
		logic [1:0] mode;
	} owm_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] read_data;
		logic       done_res;
		logic       busy_res;
		logic       drive_low;
	} owm_res_t;

endpackage

### sv/one_wire_bus_master.sv
// Each accepted item's result is registered and appears on the master side the next cycle.
// Throughput: one transaction per cycle; the sequencer advances once per accepted item, and
// a new item is taken in the same cycle as the waiting result, so a stalled result holds it.
// Reset: arst_n clears the sequencer to idle, status to success, read data to zero and
// the timing registers to their default values; no clearing pass is needed.
module one_wire_bus_master
	import owm_pkg::*;
#(
	parameter int BITS_PER_TRANSFER = 8,
	parameter int TIMER_WIDTH       = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] write_data, [8] bus_level, [9] tick, rest zero
	input  logic [1:0]  s_tuser,   // [1:0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [0] drive_low, [1] busy_res, [2] done_res,
	                               // [10:3] read_data, [12:11] status, rest zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [9:0]  cfg_data
);

	owm_cfg_t  cfg_q;
	owm_item_t item;
	owm_res_t  res;
	owm_res_t  res_q;
	logic      m_tvalid_q;
	logic      s_accept;

	assign s_tready  = !m_tvalid_q || m_tready;
	assign s_accept  = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign item.mode       = s_tuser;
	assign item.write_data = s_tdata[7:0];
	assign item.bus_level  = s_tdata[8];
	assign item.tick       = s_tdata[9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_pulse_us <= SHORT_PULSE_RST;
			cfg_q.long_pulse_us  <= LONG_PULSE_RST;
			cfg_q.pre_reset_us   <= PRE_RESET_RST;
			cfg_q.reset_low_us   <= RESET_LOW_RST;
			cfg_q.post_reset_us  <= POST_RESET_RST;
			cfg_q.read_low_us    <= READ_LOW_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SHORT_PULSE: cfg_q.short_pulse_us <= cfg_data;
				REG_LONG_PULSE:  cfg_q.long_pulse_us  <= cfg_data;
				REG_PRE_RESET:   cfg_q.pre_reset_us   <= cfg_data;
				REG_RESET_LOW:   cfg_q.reset_low_us   <= cfg_data;
				REG_POST_RESET:  cfg_q.post_reset_us  <= cfg_data;
				REG_READ_LOW:    cfg_q.read_low_us    <= cfg_data;
				default: ;
			endcase
		end
	end

	owm_seq #(
		.BITS_PER_TRANSFER(BITS_PER_TRANSFER),
		.TIMER_WIDTH      (TIMER_WIDTH)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step_en(s_accept),
		.item   (item),
		.cfg    (cfg_q),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_accept) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, res_q.status, res_q.read_data, res_q.done_res,
		res_q.busy_res, res_q.drive_low};

endmodule

### sv/owm_seq.sv
// Command sequencer of the single-wire bus master: phase state and timed transitions.
module owm_seq
	import owm_pkg::*;
#(
	parameter int BITS_PER_TRANSFER = 8,
	parameter int TIMER_WIDTH       = 10
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step_en,
	input  owm_item_t item,
	input  owm_cfg_t  cfg,
	output owm_res_t  res
);

	localparam int BIW = (BITS_PER_TRANSFER > 1) ? $clog2(BITS_PER_TRANSFER) : 1;
	localparam int CW  = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;
	localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};
	localparam logic [BIW-1:0] LAST_BIT = BIW'(BITS_PER_TRANSFER - 1);

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_RST_PRE  = 4'd1,
		PH_RST_LOW  = 4'd2,
		PH_RST_WAIT = 4'd3,
		PH_RST_POST = 4'd4,
		PH_WR_LOW   = 4'd5,
		PH_WR_HIGH  = 4'd6,
		PH_RD_LOW   = 4'd7,
		PH_RD_WAIT  = 4'd8,
		PH_RD_REC   = 4'd9,
		PH_RD_TAIL  = 4'd10
	} phase_t;

	phase_t                         phase_q, phase_n;
	logic [TIMER_WIDTH-1:0]         timer_q, timer_n, timer_inc;
	logic [BIW-1:0]                 bidx_q, bidx_n;
	logic [BITS_PER_TRANSFER-1:0]   shift_q, shift_n;
	logic [BITS_PER_TRANSFER-1:0]   rword_q, rword_n;
	logic [1:0]                     status_q, status_n;
	logic                           done;
	logic                           cur_bit;
	logic [CFG_W-1:0]               len_raw;
	logic [TIMER_WIDTH-1:0]         len;
	logic [7:0]                     rd_byte;

	// Lengths above the timer range saturate at its maximum.
	function automatic logic [TIMER_WIDTH-1:0] clip(input logic [CFG_W-1:0] v);
		logic [CW-1:0] ve;
		logic [CW-1:0] me;
		ve = CW'(v);
		me = CW'(TIMER_MAX);
		clip = (ve > me) ? TIMER_MAX : TIMER_WIDTH'(ve);
	endfunction

	assign cur_bit = shift_q[bidx_q];

	always_comb begin
		case (phase_q)
			PH_RST_PRE:  len_raw = cfg.pre_reset_us;
			PH_RST_LOW:  len_raw = cfg.reset_low_us;
			PH_RST_WAIT: len_raw = cfg.long_pulse_us;
			PH_RST_POST: len_raw = cfg.post_reset_us;
			PH_WR_LOW:   len_raw = cur_bit ? cfg.short_pulse_us : cfg.long_pulse_us;
			PH_WR_HIGH:  len_raw = cur_bit ? cfg.long_pulse_us : cfg.short_pulse_us;
			PH_RD_LOW:   len_raw = cfg.read_low_us;
			PH_RD_WAIT:  len_raw = cfg.short_pulse_us;
			default:     len_raw = cfg.long_pulse_us;
		endcase
	end

	assign len = clip(len_raw);
	assign timer_inc = (item.tick && (timer_q != TIMER_MAX)) ? timer_q + 1'b1 : timer_q;

	always_comb begin
		phase_n  = phase_q;
		timer_n  = timer_q;
		bidx_n   = bidx_q;
		shift_n  = shift_q;
		rword_n  = rword_q;
		status_n = status_q;
		done     = 1'b0;
		if (phase_q == PH_IDLE) begin
			if (item.mode != CMD_NONE) begin
				bidx_n  = '0;
				timer_n = '0;
				case (item.mode)
					CMD_RESET: begin
						phase_n = PH_RST_PRE;
					end
					CMD_WRITE: begin
						phase_n = PH_WR_LOW;
						for (int i = 0; i < BITS_PER_TRANSFER; i++) begin
							shift_n[i] = (i < 8) ? item.write_data[i % 8] : 1'b0;
						end
					end
					default: begin
						phase_n = PH_RD_LOW;
						shift_n = '0;
					end
				endcase
			end
		end else begin
			timer_n = timer_inc;
			if (timer_inc >= len) begin
				timer_n = '0;
				case (phase_q)
					PH_RST_PRE: begin
						if (item.bus_level) begin
							phase_n = PH_RST_LOW;
						end else begin
							phase_n  = PH_IDLE;
							status_n = ST_BUS_LOW;
							done     = 1'b1;
						end
					end
					PH_RST_LOW: begin
						phase_n = PH_RST_WAIT;
					end
					PH_RST_WAIT: begin
						if (item.bus_level) begin
							phase_n  = PH_IDLE;
							status_n = ST_NO_ECHO;
							done     = 1'b1;
						end else begin
							phase_n = PH_RST_POST;
						end
					end
					PH_RST_POST: begin
						phase_n  = PH_IDLE;
						status_n = ST_OK;
						done     = 1'b1;
					end
					PH_WR_LOW: begin
						phase_n = PH_WR_HIGH;
					end
					PH_WR_HIGH: begin
						if (bidx_q == LAST_BIT) begin
							phase_n  = PH_IDLE;
							status_n = ST_OK;
							done     = 1'b1;
						end else begin
							bidx_n  = bidx_q + 1'b1;
							phase_n = PH_WR_LOW;
						end
					end
					PH_RD_LOW: begin
						phase_n = PH_RD_WAIT;
					end
					PH_RD_WAIT: begin
						if (item.bus_level) begin
							shift_n[bidx_q] = 1'b1;
						end
						phase_n = PH_RD_REC;
					end
					PH_RD_REC: begin
						if (bidx_q == LAST_BIT) begin
							phase_n = PH_RD_TAIL;
						end else begin
							bidx_n  = bidx_q + 1'b1;
							phase_n = PH_RD_LOW;
						end
					end
					PH_RD_TAIL: begin
						rword_n  = shift_q;
						phase_n  = PH_IDLE;
						status_n = ST_OK;
						done     = 1'b1;
					end
					default: begin
						phase_n = PH_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			timer_q  <= '0;
			bidx_q   <= '0;
			shift_q  <= '0;
			rword_q  <= '0;
			status_q <= ST_OK;
		end else if (step_en) begin
			phase_q  <= phase_n;
			timer_q  <= timer_n;
			bidx_q   <= bidx_n;
			shift_q  <= shift_n;
			rword_q  <= rword_n;
			status_q <= status_n;
		end
	end

	// Only the low byte of the assembled word is reported.
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			rd_byte[i] = (i < BITS_PER_TRANSFER) ? rword_n[i % BITS_PER_TRANSFER] : 1'b0;
		end
	end

	assign res.drive_low = (phase_n == PH_RST_LOW) || (phase_n == PH_WR_LOW) ||
		(phase_n == PH_RD_LOW);
	assign res.busy_res  = (phase_n != PH_IDLE);
	assign res.done_res  = done;
	assign res.read_data = rd_byte;
	assign res.status    = status_n;

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the single-wire bus master: streamed clock items in, one checked result per item out.
module tb_top;
	import owm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF      = 10;
	localparam int RESET_CYCLES  = 9;
	localparam int XFER_BITS     = 8;
	localparam int QUIET_CYCLES  = 4;
	localparam int DRAIN_LIMIT   = 2000;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int PRINT_LIMIT   = 25;
	localparam int RANDOM_ITEMS  = 150;
	localparam logic [9:0] TIMER_MAX = 10'h3FF;

	// Register indexes that the block has no register for.
	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	// How the bus answers at the sample points of a reset command.
	localparam int FAULT_NONE    = 0;
	localparam int FAULT_STUCK   = 1;
	localparam int FAULT_NO_ECHO = 2;
	localparam int FAULT_RANDOM  = 3;

	// Receiver stall patterns.
	localparam int STALL_NONE   = 0;
	localparam int STALL_RANDOM = 1;
	localparam int STALL_SPARSE = 2;

	typedef enum logic [3:0] {
		SEQ_IDLE, SEQ_RST_PRE, SEQ_RST_LOW, SEQ_RST_WAIT, SEQ_RST_POST,
		SEQ_WR_LOW, SEQ_WR_HIGH, SEQ_RD_LOW, SEQ_RD_WAIT, SEQ_RD_REC, SEQ_RD_TAIL
	} seq_phase_e;

	typedef struct packed {
		seq_phase_e phase;
		logic [9:0] timer;
		logic [2:0] bit_idx;
		logic [7:0] shift;
		logic [1:0] status;
		logic [7:0] rd_byte;
	} bus_state_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [9:0]  cfg_data = '0;

	one_wire_bus_master dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #(CLK_HALF) clk = ~clk;

	owm_item_t  pending_items[$];
	owm_res_t   expected_results[$];
	bus_state_t line_state;
	bus_state_t plan_state;
	owm_cfg_t   line_timing;
	owm_cfg_t   plan_timing;

	int mismatches = 0;
	int results_checked = 0;
	int phase_items = 0;
	int settings_used = 0;
	int commands_sent[4];
	int ends_by_status[4];
	int unsigned cycles = 0;

	function automatic owm_cfg_t default_timing();
		owm_cfg_t c;
		c.short_pulse_us = SHORT_PULSE_RST;
		c.long_pulse_us  = LONG_PULSE_RST;
		c.pre_reset_us   = PRE_RESET_RST;
		c.reset_low_us   = RESET_LOW_RST;
		c.post_reset_us  = POST_RESET_RST;
		c.read_low_us    = READ_LOW_RST;
		return c;
	endfunction

	function automatic void apply_reg(inout owm_cfg_t c, input logic [2:0] idx,
			input logic [9:0] val);
		case (idx)
			REG_SHORT_PULSE: c.short_pulse_us = val;
			REG_LONG_PULSE:  c.long_pulse_us  = val;
			REG_PRE_RESET:   c.pre_reset_us   = val;
			REG_RESET_LOW:   c.reset_low_us   = val;
			REG_POST_RESET:  c.post_reset_us  = val;
			REG_READ_LOW:    c.read_low_us    = val;
			default: ;
		endcase
	endfunction

	function automatic logic [9:0] slot_length(input bus_state_t s, input owm_cfg_t c);
		logic one;
		one = s.shift[s.bit_idx];
		case (s.phase)
			SEQ_RST_PRE:  return c.pre_reset_us;
			SEQ_RST_LOW:  return c.reset_low_us;
			SEQ_RST_WAIT: return c.long_pulse_us;
			SEQ_RST_POST: return c.post_reset_us;
			SEQ_WR_LOW:   return one ? c.short_pulse_us : c.long_pulse_us;
			SEQ_WR_HIGH:  return one ? c.long_pulse_us : c.short_pulse_us;
			SEQ_RD_LOW:   return c.read_low_us;
			SEQ_RD_WAIT:  return c.short_pulse_us;
			default:      return c.long_pulse_us;
		endcase
	endfunction

	// Advances the sequencer by one clock item and returns what the outputs show after it.
	function automatic owm_res_t bus_cycle(inout bus_state_t s, input owm_cfg_t c,
			input owm_item_t it);
		owm_res_t r;
		logic fin;
		logic [1:0] fin_status;
		fin = 1'b0;
		fin_status = ST_OK;
		if (s.phase == SEQ_IDLE) begin
			if (it.mode != CMD_NONE) begin
				s.bit_idx = '0;
				s.timer = '0;
				case (it.mode)
					CMD_RESET: s.phase = SEQ_RST_PRE;
					CMD_WRITE: begin
						s.shift = it.write_data;
						s.phase = SEQ_WR_LOW;
					end
					default: begin
						s.shift = '0;
						s.phase = SEQ_RD_LOW;
					end
				endcase
			end
		end else begin
			if (it.tick && s.timer != TIMER_MAX)
				s.timer = s.timer + 10'd1;
			if (s.timer >= slot_length(s, c)) begin
				s.timer = '0;
				case (s.phase)
					SEQ_RST_PRE: begin
						if (it.bus_level)
							s.phase = SEQ_RST_LOW;
						else begin
							fin = 1'b1;
							fin_status = ST_BUS_LOW;
						end
					end
					SEQ_RST_LOW: s.phase = SEQ_RST_WAIT;
					SEQ_RST_WAIT: begin
						if (it.bus_level) begin
							fin = 1'b1;
							fin_status = ST_NO_ECHO;
						end else
							s.phase = SEQ_RST_POST;
					end
					SEQ_RST_POST: fin = 1'b1;
					SEQ_WR_LOW: s.phase = SEQ_WR_HIGH;
					SEQ_WR_HIGH: begin
						if (int'(s.bit_idx) + 1 >= XFER_BITS)
							fin = 1'b1;
						else begin
							s.bit_idx = s.bit_idx + 3'd1;
							s.phase = SEQ_WR_LOW;
						end
					end
					SEQ_RD_LOW: s.phase = SEQ_RD_WAIT;
					SEQ_RD_WAIT: begin
						if (it.bus_level)
							s.shift[s.bit_idx] = 1'b1;
						s.phase = SEQ_RD_REC;
					end
					SEQ_RD_REC: begin
						if (int'(s.bit_idx) + 1 >= XFER_BITS)
							s.phase = SEQ_RD_TAIL;
						else begin
							s.bit_idx = s.bit_idx + 3'd1;
							s.phase = SEQ_RD_LOW;
						end
					end
					SEQ_RD_TAIL: begin
						s.rd_byte = s.shift;
						fin = 1'b1;
					end
					default: s.phase = SEQ_IDLE;
				endcase
				if (fin) begin
					s.phase = SEQ_IDLE;
					s.status = fin_status;
				end
			end
		end
		r.drive_low = (s.phase == SEQ_RST_LOW || s.phase == SEQ_WR_LOW ||
			s.phase == SEQ_RD_LOW);
		r.busy_res  = (s.phase != SEQ_IDLE);
		r.done_res  = fin;
		r.read_data = s.rd_byte;
		r.status    = s.status;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("MISMATCH %s: got %0h, expected %0h (result %0d, %0t)",
				what, got, want, results_checked, $realtime);
	endtask

	// Sender: bursts of random length separated by random gaps.
	owm_item_t drv_item;
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (pending_items.size() != 0) begin
				drv_item = pending_items.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {6'd0, drv_item.tick, drv_item.bus_level, drv_item.write_data};
				s_tuser <= drv_item.mode;
				if (burst_left > 0)
					burst_left--;
				else begin
					burst_left = $urandom_range(0, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
				end
			end else
				s_tvalid <= 1'b0;
		end
	end

	// Receiver: stretches of full readiness, random stalls and a sparse fixed pattern.
	int stall_kind = STALL_NONE;
	int stall_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else begin
			if (stall_left == 0) begin
				stall_kind = $urandom_range(STALL_NONE, STALL_SPARSE);
				stall_left = $urandom_range(10, 200);
			end else
				stall_left--;
			case (stall_kind)
				STALL_NONE:   m_tready <= 1'b1;
				STALL_RANDOM: m_tready <= ($urandom_range(0, 99) >= 35);
				default:      m_tready <= (stall_left % 4 == 0);
			endcase
		end
	end

	// Every accepted item and register write updates the predicted sequencer.
	owm_item_t seen_item;

	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready)
			apply_reg(line_timing, cfg_index, cfg_data);
		if (arst_n && s_tvalid && s_tready) begin
			seen_item.mode = s_tuser;
			seen_item.write_data = s_tdata[7:0];
			seen_item.bus_level = s_tdata[8];
			seen_item.tick = s_tdata[9];
			expected_results.push_back(bus_cycle(line_state, line_timing, seen_item));
		end
	end

	owm_res_t want;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0)
				report_mismatch("result with nothing outstanding", int'(m_tdata), 0);
			else begin
				want = expected_results.pop_front();
				if (m_tdata[0] !== want.drive_low)
					report_mismatch("drive_low", int'(m_tdata[0]), int'(want.drive_low));
				if (m_tdata[1] !== want.busy_res)
					report_mismatch("busy_res", int'(m_tdata[1]), int'(want.busy_res));
				if (m_tdata[2] !== want.done_res)
					report_mismatch("done_res", int'(m_tdata[2]), int'(want.done_res));
				if (m_tdata[10:3] !== want.read_data)
					report_mismatch("read_data", int'(m_tdata[10:3]), int'(want.read_data));
				if (m_tdata[12:11] !== want.status)
					report_mismatch("status", int'(m_tdata[12:11]), int'(want.status));
				if (m_tdata[15:13] !== 3'd0)
					report_mismatch("padding", int'(m_tdata[15:13]), 0);
				if (want.done_res)
					ends_by_status[want.status]++;
				results_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic push_item(input owm_item_t it);
		pending_items.push_back(it);
		void'(bus_cycle(plan_state, plan_timing, it));
		phase_items++;
	endtask

	task automatic idle_items(input int n);
		owm_item_t it;
		for (int i = 0; i < n; i++) begin
			it.mode = CMD_NONE;
			it.write_data = 8'($urandom);
			it.bus_level = 1'($urandom_range(0, 1));
			it.tick = 1'($urandom_range(0, 1));
			push_item(it);
		end
	endtask

	// Queues one command and the clock items that carry it through to its end.
	task automatic run_command(input logic [1:0] cmd, input logic [7:0] data, input int fault,
			input int ones_pct, input int tick_pct);
		owm_item_t it;
		logic first;
		first = 1'b1;
		commands_sent[cmd]++;
		do begin
			if (first)
				it.mode = cmd;
			else
				it.mode = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) : CMD_NONE;
			it.write_data = first ? data : 8'($urandom);
			it.tick = ($urandom_range(0, 99) < tick_pct);
			case (plan_state.phase)
				SEQ_RST_PRE: it.bus_level = !(fault == FAULT_STUCK ||
					(fault == FAULT_RANDOM && $urandom_range(0, 99) < 12));
				SEQ_RST_WAIT: it.bus_level = (fault == FAULT_NO_ECHO ||
					(fault == FAULT_RANDOM && $urandom_range(0, 99) < 12));
				SEQ_RD_WAIT: it.bus_level = ($urandom_range(0, 99) < ones_pct);
				default: it.bus_level = 1'($urandom_range(0, 1));
			endcase
			push_item(it);
			first = 1'b0;
		end while (plan_state.phase != SEQ_IDLE);
	endtask

	task automatic random_phase(input int n_items);
		logic [1:0] cmd;
		phase_items = 0;
		while (phase_items < n_items) begin
			if ($urandom_range(0, 4) == 0)
				idle_items($urandom_range(1, 4));
			cmd = 2'($urandom_range(CMD_RESET, CMD_READ));
			run_command(cmd, 8'($urandom), FAULT_RANDOM, 50, 75);
		end
	endtask

	// Waits until every queued item has been sent and every outstanding result has been taken.
	task automatic wait_quiet();
		do @(posedge clk);
		while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [9:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		apply_reg(plan_timing, idx, val);
	endtask

	task automatic set_timing(input logic [9:0] short_us, input logic [9:0] long_us,
			input logic [9:0] pre_us, input logic [9:0] low_us, input logic [9:0] post_us,
			input logic [9:0] rd_low_us);
		write_reg(REG_SHORT_PULSE, short_us);
		write_reg(REG_LONG_PULSE, long_us);
		write_reg(REG_PRE_RESET, pre_us);
		write_reg(REG_RESET_LOW, low_us);
		write_reg(REG_POST_RESET, post_us);
		write_reg(REG_READ_LOW, rd_low_us);
		settings_used++;
	endtask

	function automatic logic [9:0] random_length(input int floor);
		if ($urandom_range(0, 9) == 0)
			return 10'($urandom_range(floor, 40));
		return 10'($urandom_range(floor, 6));
	endfunction

	initial begin
		int waited;
		line_state = '0;
		plan_state = '0;
		line_state.phase = SEQ_IDLE;
		plan_state.phase = SEQ_IDLE;
		line_timing = default_timing();
		plan_timing = default_timing();
		for (int i = 0; i < 4; i++) begin
			commands_sent[i] = 0;
			ends_by_status[i] = 0;
		end
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Timing left at its reset values.
		settings_used = 1;
		idle_items(3);
		run_command(CMD_WRITE, 8'hA5, FAULT_NONE, 50, 100);
		wait_quiet();

		// Writes to unused indexes must leave the timing untouched.
		write_reg(REG_SPARE_LO, 10'h3FF);
		write_reg(REG_SPARE_HI, 10'h000);
		set_timing(10'd2, 10'd3, 10'd0, 10'd1, 10'd0, 10'd1);
		run_command(CMD_RESET, 8'hFF, FAULT_NONE, 50, 100);
		run_command(CMD_RESET, 8'h00, FAULT_STUCK, 50, 100);
		run_command(CMD_RESET, 8'h5A, FAULT_NO_ECHO, 50, 100);
		run_command(CMD_RESET, 8'h81, FAULT_NONE, 50, 30);
		run_command(CMD_WRITE, 8'h00, FAULT_NONE, 50, 100);
		run_command(CMD_WRITE, 8'hFF, FAULT_NONE, 50, 60);
		run_command(CMD_READ, 8'h00, FAULT_NONE, 100, 100);
		run_command(CMD_READ, 8'hFF, FAULT_NONE, 0, 100);
		idle_items(2);
		wait_quiet();

		// Shortest phases, then random timing.
		set_timing(10'd1, 10'd1, 10'd0, 10'd1, 10'd0, 10'd1);
		random_phase(RANDOM_ITEMS);
		repeat (4) begin
			wait_quiet();
			set_timing(random_length(1), random_length(1), random_length(0),
				random_length(1), random_length(0), random_length(1));
			random_phase(RANDOM_ITEMS);
		end

		while (pending_items.size() != 0 || s_tvalid)
			@(posedge clk);
		waited = 0;
		while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (QUIET_CYCLES) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch("results never delivered", expected_results.size(), 0);

		$display("Covered %0d reset, %0d write and %0d read commands over %0d timing settings;",
			commands_sent[CMD_RESET], commands_sent[CMD_WRITE], commands_sent[CMD_READ],
			settings_used);
		$display("%0d results checked, commands ending ok %0d, bus stuck low %0d, no echo %0d.",
			results_checked, ends_by_status[ST_OK], ends_by_status[ST_BUS_LOW],
			ends_by_status[ST_NO_ECHO]);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
